// ===== rtl/mdul_pkg.sv =====
// Shared types and constants of the anisotropic Morton index decoder.
package mdul_pkg;

   // field widths
   localparam int LevelW  = 5;
   localparam int InW     = 60;
   localparam int OutW    = 20;
   localparam int CsrIdxW = 2;

   // largest usable refinement level; larger settings saturate
   localparam logic [LevelW-1:0] MaxLevel = LevelW'(20);

   // part of the low bits taken from the once-shifted index
   localparam int MidW = 2 * OutW;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_LEVEL_X = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CSR_LEVEL_Y = CsrIdxW'(1);
   localparam logic [CsrIdxW-1:0] CSR_LEVEL_Z = CsrIdxW'(2);

   // place of a dimension in the ascending level order
   typedef enum logic [1:0] {
      ROLE_LOW = 2'd0,
      ROLE_MID = 2'd1,
      ROLE_TOP = 2'd2
   } role_type;

   // bit order derived from the configured levels
   typedef struct packed {
      role_type          role_x;
      role_type          role_y;
      role_type          role_z;
      logic [LevelW-1:0] lev_low;
      logic [LevelW-1:0] lev_mid;
   } order_type;

endpackage

// ===== rtl/morton_decode_unequal_levels.sv =====
// Top level of the anisotropic Morton index decoder pipeline.
//
// Splits a 60-bit interleaved Morton index into three 20-bit segment indices.
// Each dimension has its own refinement level (0..20, larger values saturate),
// written through the csr_ port: csr_index 0, 1, 2 select level x, y, z;
// other indexes are ignored. csr_ready is always high. Levels reset to zero,
// which sends the low 20 index bits to the z dimension.
// A word is taken on each clock edge with start high; busy is always low, so
// a new index may enter every cycle (one word per cycle sustained).
// The stages are: order by level, shift by the lowest level, shift by
// the middle level, then assemble and route to the dimensions. The result is
// on rsp_index_* for one cycle, marked by rsp_valid; the receiver cannot stall,
// so nothing is held back. Reset clears the pipeline valid bits and levels.
// The user must change levels only while no word is in flight; the block does not enforce it.
module morton_decode_unequal_levels (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [mdul_pkg::InW-1:0]     req_z_index,
   output logic                         rsp_valid,
   output logic [mdul_pkg::OutW-1:0]    rsp_index_x,
   output logic [mdul_pkg::OutW-1:0]    rsp_index_y,
   output logic [mdul_pkg::OutW-1:0]    rsp_index_z,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mdul_pkg::CsrIdxW-1:0] csr_index,
   input  logic [mdul_pkg::LevelW-1:0]  csr_data
);
   import mdul_pkg::*;

   // configuration registers
   logic [LevelW-1:0] level_x_ff, level_y_ff, level_z_ff;

   // pipeline registers
   logic            v1_ff, v2_ff, v3_ff, v4_ff;
   logic [InW-1:0]  z1_ff, z2_ff, z3_ff;
   logic [InW-1:0]  zs1_2_ff;
   logic [MidW-1:0] zs1_3_ff;
   logic [OutW-1:0] zs2_3_ff;
   order_type       ord1_ff, ord2_ff, ord3_ff;
   logic [OutW-1:0] idx_x_ff, idx_y_ff, idx_z_ff;

   order_type       ord_in;
   logic [InW-1:0]  zs2_in;
   logic [OutW-1:0] role_low, role_mid, role_top;
   logic [OutW-1:0] idx_x_in, idx_y_in, idx_z_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // level register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         level_x_ff <= '0;
         level_y_ff <= '0;
         level_z_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LEVEL_X: level_x_ff <= csr_data;
            CSR_LEVEL_Y: level_y_ff <= csr_data;
            CSR_LEVEL_Z: level_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: order dimensions by level
   mdul_order u_order (
      .level_x (level_x_ff),
      .level_y (level_y_ff),
      .level_z (level_z_ff),
      .order   (ord_in)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // second shift: by the middle level
   assign zs2_in = zs1_2_ff >> ord2_ff.lev_mid;

   // payload stages
   always_ff @(posedge clock) begin
      z1_ff    <= req_z_index;
      ord1_ff  <= ord_in;
      z2_ff    <= z1_ff;
      zs1_2_ff <= z1_ff >> ord1_ff.lev_low;
      ord2_ff  <= ord1_ff;
      z3_ff    <= z2_ff;
      zs1_3_ff <= zs1_2_ff[MidW-1:0];
      zs2_3_ff <= zs2_in[OutW-1:0];
      ord3_ff  <= ord2_ff;
      idx_x_ff <= idx_x_in;
      idx_y_ff <= idx_y_in;
      idx_z_ff <= idx_z_in;
   end

   // stage 4: gather bits for each place in the order
   always_comb begin
      for (int b = 0; b < OutW; b++) begin
         if (LevelW'(b) < ord3_ff.lev_low) begin
            role_low[b] = z3_ff[3*b];
            role_mid[b] = z3_ff[3*b+1];
            role_top[b] = z3_ff[3*b+2];
         end else if (LevelW'(b) < ord3_ff.lev_mid) begin
            role_low[b] = 1'b0;
            role_mid[b] = zs1_3_ff[2*b];
            role_top[b] = zs1_3_ff[2*b+1];
         end else begin
            // top dimension also takes every leftover bit
            role_low[b] = 1'b0;
            role_mid[b] = 1'b0;
            role_top[b] = zs2_3_ff[b];
         end
      end
   end

   // route each place back to its dimension
   function automatic logic [OutW-1:0] pick(
      input role_type        role,
      input logic [OutW-1:0] low,
      input logic [OutW-1:0] mid,
      input logic [OutW-1:0] top
   );
      logic [OutW-1:0] r;
      unique case (role)
         ROLE_LOW: r = low;
         ROLE_MID: r = mid;
         ROLE_TOP: r = top;
         default:  r = '0;
      endcase
      return r;
   endfunction

   always_comb begin
      idx_x_in = pick(ord3_ff.role_x, role_low, role_mid, role_top);
      idx_y_in = pick(ord3_ff.role_y, role_low, role_mid, role_top);
      idx_z_in = pick(ord3_ff.role_z, role_low, role_mid, role_top);
   end

   assign rsp_valid   = v4_ff;
   assign rsp_index_x = idx_x_ff;
   assign rsp_index_y = idx_y_ff;
   assign rsp_index_z = idx_z_ff;

endmodule

// ===== rtl/mdul_order.sv =====
// Level saturation and stable ascending sort of the three dimensions.
module mdul_order (
   input  logic [mdul_pkg::LevelW-1:0] level_x,
   input  logic [mdul_pkg::LevelW-1:0] level_y,
   input  logic [mdul_pkg::LevelW-1:0] level_z,
   output mdul_pkg::order_type         order
);
   import mdul_pkg::*;

   logic [LevelW-1:0] lx, ly, lz;
   logic [1:0]        rank_x, rank_y, rank_z;

   // saturate levels
   always_comb begin
      lx = (level_x > MaxLevel) ? MaxLevel : level_x;
      ly = (level_y > MaxLevel) ? MaxLevel : level_y;
      lz = (level_z > MaxLevel) ? MaxLevel : level_z;
   end

   // rank = number of dimensions ahead in the order; ties go by dimension number
   always_comb begin
      rank_x = 2'(ly < lx) + 2'(lz < lx);
      rank_y = 2'(lx <= ly) + 2'(lz < ly);
      rank_z = 2'(lx <= lz) + 2'(ly <= lz);
   end

   // pick the two lower levels by rank
   always_comb begin
      order.role_x  = role_type'(rank_x);
      order.role_y  = role_type'(rank_y);
      order.role_z  = role_type'(rank_z);
      order.lev_low = lz;
      order.lev_mid = lz;
      if (rank_x == 2'(ROLE_LOW)) begin
         order.lev_low = lx;
      end else if (rank_y == 2'(ROLE_LOW)) begin
         order.lev_low = ly;
      end
      if (rank_x == 2'(ROLE_MID)) begin
         order.lev_mid = lx;
      end else if (rank_y == 2'(ROLE_MID)) begin
         order.lev_mid = ly;
      end
   end

endmodule
